/* rtl/core/swwa_pkg.sv */
package swwa_pkg;

    localparam int MODE_W   = 3;
    localparam int SMP_W    = 32;
    localparam int SUM_W    = 40;
    localparam int AVG_W    = 32;
    localparam int OFFSET_W = 4;
    localparam int TICK_W   = 16;

    localparam int WINDOW_BUCKETS_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WR_VAL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WR_WT  = 3'd5;

    typedef struct packed {
        logic latch;
        logic rd_exec;
        logic exec;
        logic div_start;
        logic avg_wr;
        logic out_load;
    } swwa_cmd_t;

    typedef struct packed {
        logic advance;
        logic div_done;
    } swwa_sts_t;

endpackage

/* rtl/core/swwa_if.sv */
interface swwa_in_if import swwa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [SMP_W-1:0]    sample_value;
    logic signed [SMP_W-1:0]    sample_weight;
    logic [OFFSET_W-1:0]        bucket_offset;

    modport source (output valid, mode, sample_value, sample_weight, bucket_offset,
                    input ready);
    modport sink   (input valid, mode, sample_value, sample_weight, bucket_offset,
                    output ready);
endinterface

interface swwa_out_if import swwa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [AVG_W-1:0]    current_average;
    logic signed [SUM_W-1:0]    total_value_out;
    logic signed [SUM_W-1:0]    total_weight_out;
    logic signed [SUM_W-1:0]    read_value;
    logic signed [SUM_W-1:0]    read_weight;
    logic signed [AVG_W-1:0]    read_average;

    modport source (output valid, current_average, total_value_out, total_weight_out,
                    read_value, read_weight, read_average,
                    input ready);
    modport sink   (input valid, current_average, total_value_out, total_weight_out,
                    read_value, read_weight, read_average,
                    output ready);
endinterface

/* rtl/core/sliding_window_weighted_average.sv */
// Sliding-window weighted average over a ring of WINDOW_BUCKETS buckets. Items
// are taken one at a time: once an item is accepted, the block reads its
// bucket, updates it and loads the result into the output register, and only
// then is the input ready again. A tick that advances the window also runs
// the 40-bit restoring divider, one quotient bit per cycle, and skips the
// division when the weight sum is zero. The next item may be accepted while
// the previous result is still waiting on the output; that next item then
// holds in its last step until the output register frees. ticks_per_bucket
// is written through cfg_we/cfg_wdata while the block is idle: the user must
// keep to this, the block does not enforce it.
module sliding_window_weighted_average import swwa_pkg::*;
#(
    parameter int WINDOW_BUCKETS = WINDOW_BUCKETS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [TICK_W-1:0]   cfg_wdata,
    swwa_in_if.sink             req,
    swwa_out_if.source          rsp
);

    swwa_cmd_t cmd;
    swwa_sts_t sts;
    logic      in_ready;
    logic      out_valid;

    swwa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_ready (rsp.ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    swwa_dp #(
        .WINDOW_BUCKETS (WINDOW_BUCKETS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .sts              (sts),
        .mode             (req.mode),
        .sample_value     (req.sample_value),
        .sample_weight    (req.sample_weight),
        .bucket_offset    (req.bucket_offset),
        .current_average  (rsp.current_average),
        .total_value_out  (rsp.total_value_out),
        .total_weight_out (rsp.total_weight_out),
        .read_value       (rsp.read_value),
        .read_weight      (rsp.read_weight),
        .read_average     (rsp.read_average)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("input taken again while an item is in work");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> rsp.valid)
        else $error("result loaded but output not valid");

endmodule

/* rtl/core/swwa_div.sv */
module swwa_div import swwa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SUM_W-1:0]        num,
    input  logic [SUM_W-1:0]        den,
    output logic                    done,
    output logic [AVG_W-1:0]        quot
);

    localparam int CNT_W = $clog2(SUM_W);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIN  = 2'd2;

    localparam logic [SUM_W-1:0] POS_LIM = SUM_W'({1'b0, {(AVG_W-1){1'b1}}});
    localparam logic [SUM_W-1:0] NEG_LIM = SUM_W'({1'b1, {(AVG_W-1){1'b0}}});

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [SUM_W:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [SUM_W-1:0]   dmag_reg, dmag_next;
    logic               neg_reg, neg_next;
    logic [AVG_W-1:0]   q_reg, q_next;

    logic [SUM_W:0]     shifted;
    logic [SUM_W:0]     diff;
    logic [SUM_W-1:0]   nmag;
    logic [SUM_W-1:0]   dmag_in;
    logic [SUM_W-1:0]   qneg;

    always_comb
    begin
        nmag    = num[SUM_W-1] ? (~num + 1'b1) : num;
        dmag_in = den[SUM_W-1] ? (~den + 1'b1) : den;
        shifted = {rem_reg[SUM_W-1:0], quo_reg[SUM_W-1]};
        diff    = shifted - {1'b0, dmag_reg};
        qneg    = ~quo_reg + 1'b1;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        q_next     = q_reg;

        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    if (den == '0)
                    begin
                        q_next    = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = nmag;
                        dmag_next  = dmag_in;
                        neg_next   = num[SUM_W-1] ^ den[SUM_W-1];
                        cnt_next   = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                // restoring division, one quotient bit per cycle
                if (!diff[SUM_W])
                begin
                    rem_next = diff;
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W-1))
                    state_next = D_FIN;
            end
            D_FIN:
            begin
                if (neg_reg)
                    q_next = (quo_reg > NEG_LIM) ? NEG_LIM[AVG_W-1:0] : qneg[AVG_W-1:0];
                else
                    q_next = (quo_reg > POS_LIM) ? POS_LIM[AVG_W-1:0] : quo_reg[AVG_W-1:0];
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* rtl/core/swwa_ctrl.sv */
module swwa_ctrl import swwa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_ready,
    output logic        out_valid,
    input  swwa_sts_t   sts,
    output swwa_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_FETCH  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_exec = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.advance ? S_DSTART : S_FETCH;
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.avg_wr = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // result goes straight into the output register once it is free
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/swwa_dp.sv */
module swwa_dp import swwa_pkg::*;
#(
    parameter int WINDOW_BUCKETS = WINDOW_BUCKETS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [TICK_W-1:0]       cfg_wdata,
    input  swwa_cmd_t               cmd,
    output swwa_sts_t               sts,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [SMP_W-1:0] sample_value,
    input  logic signed [SMP_W-1:0] sample_weight,
    input  logic [OFFSET_W-1:0]     bucket_offset,
    output logic signed [AVG_W-1:0] current_average,
    output logic signed [SUM_W-1:0] total_value_out,
    output logic signed [SUM_W-1:0] total_weight_out,
    output logic signed [SUM_W-1:0] read_value,
    output logic signed [SUM_W-1:0] read_weight,
    output logic signed [AVG_W-1:0] read_average
);

    localparam int IDX_W   = $clog2(WINDOW_BUCKETS);
    localparam int OFFSETS = 2**OFFSET_W;

    // offset reduced modulo the ring size
    logic [IDX_W-1:0] off_tab [OFFSETS];

    for (genvar g = 0; g < OFFSETS; g++)
    begin : g_off
        localparam int OM = g % WINDOW_BUCKETS;
        assign off_tab[g] = IDX_W'(OM);
    end

    // bucket store, with per-entry valid bits standing in for the zero reset
    logic [SUM_W-1:0]           val_mem [WINDOW_BUCKETS];
    logic [SUM_W-1:0]           wt_mem  [WINDOW_BUCKETS];
    logic [AVG_W-1:0]           avg_mem [WINDOW_BUCKETS];
    logic [WINDOW_BUCKETS-1:0]  bkt_vld_reg;
    logic [WINDOW_BUCKETS-1:0]  avg_vld_reg;

    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [TICK_W-1:0]  tpb_reg;
    logic [SUM_W-1:0]   vsum_reg, vsum_next;
    logic [SUM_W-1:0]   wsum_reg, wsum_next;

    logic [MODE_W-1:0]  mode_reg;
    logic [SUM_W-1:0]   v_reg;
    logic [SUM_W-1:0]   w_reg;
    logic [IDX_W-1:0]   off_reg;
    logic [SUM_W-1:0]   ex_val_reg;
    logic [SUM_W-1:0]   ex_wt_reg;

    logic [AVG_W-1:0]   cur_avg_reg;
    logic [SUM_W-1:0]   tot_val_reg;
    logic [SUM_W-1:0]   tot_wt_reg;
    logic [SUM_W-1:0]   rd_val_reg;
    logic [SUM_W-1:0]   rd_wt_reg;
    logic [AVG_W-1:0]   rd_avg_reg;

    logic [IDX_W:0]     a_sum;
    logic [IDX_W-1:0]   a_addr;
    logic [IDX_W-1:0]   ptr_inc;
    logic [IDX_W-1:0]   ex_addr;
    logic [TICK_W-1:0]  period;
    logic [TICK_W:0]    tick_inc;
    logic               advance;
    logic               wr_en;
    logic [SUM_W-1:0]   wr_val;
    logic [SUM_W-1:0]   wr_wt;
    logic               div_done;
    logic [AVG_W-1:0]   div_q;

    always_comb
    begin
        a_sum  = {1'b0, ptr_reg} + {1'b0, off_reg};
        a_addr = (a_sum >= (IDX_W+1)'(WINDOW_BUCKETS))
               ? IDX_W'(a_sum - (IDX_W+1)'(WINDOW_BUCKETS))
               : a_sum[IDX_W-1:0];
        ptr_inc = (ptr_reg == IDX_W'(WINDOW_BUCKETS-1)) ? '0 : ptr_reg + 1'b1;

        period   = (tpb_reg == '0) ? TICK_W'(1) : tpb_reg;
        tick_inc = {1'b0, tick_reg} + 1'b1;
        advance  = (mode_reg == MODE_TICK) && (tick_inc >= {1'b0, period});

        case (mode_reg) inside
            MODE_ADD, MODE_SUB: ex_addr = ptr_reg;
            MODE_TICK:          ex_addr = ptr_inc;
            default:            ex_addr = a_addr;
        endcase
    end

    always_comb
    begin
        wr_en     = 1'b0;
        wr_val    = ex_val_reg;
        wr_wt     = ex_wt_reg;
        vsum_next = vsum_reg;
        wsum_next = wsum_reg;
        tick_next = tick_reg;
        ptr_next  = ptr_reg;

        if (cmd.exec)
        begin
            case (mode_reg)
                MODE_ADD:
                begin
                    wr_en     = 1'b1;
                    wr_val    = ex_val_reg + v_reg;
                    wr_wt     = ex_wt_reg + w_reg;
                    vsum_next = vsum_reg + v_reg;
                    wsum_next = wsum_reg + w_reg;
                end
                MODE_SUB:
                begin
                    wr_en     = 1'b1;
                    wr_val    = ex_val_reg - v_reg;
                    wr_wt     = ex_wt_reg - w_reg;
                    vsum_next = vsum_reg - v_reg;
                    wsum_next = wsum_reg - w_reg;
                end
                MODE_TICK:
                begin
                    if (advance)
                    begin
                        // oldest bucket leaves the window and is cleared
                        tick_next = '0;
                        ptr_next  = ptr_inc;
                        wr_en     = 1'b1;
                        wr_val    = '0;
                        wr_wt     = '0;
                        vsum_next = vsum_reg - ex_val_reg;
                        wsum_next = wsum_reg - ex_wt_reg;
                    end
                    else
                    begin
                        tick_next = tick_inc[TICK_W-1:0];
                    end
                end
                MODE_WR_VAL:
                begin
                    wr_en     = 1'b1;
                    wr_val    = v_reg;
                    vsum_next = vsum_reg - ex_val_reg + v_reg;
                end
                MODE_WR_WT:
                begin
                    wr_en     = 1'b1;
                    wr_wt     = w_reg;
                    wsum_next = wsum_reg - ex_wt_reg + w_reg;
                end
                MODE_READ: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            tick_reg    <= '0;
            tpb_reg     <= TICK_W'(1);
            vsum_reg    <= '0;
            wsum_reg    <= '0;
            bkt_vld_reg <= '0;
            avg_vld_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            tick_reg <= tick_next;
            vsum_reg <= vsum_next;
            wsum_reg <= wsum_next;
            if (cfg_we)
                tpb_reg <= cfg_wdata;
            if (cmd.exec && wr_en)
                bkt_vld_reg[ex_addr] <= 1'b1;
            if (cmd.avg_wr)
                avg_vld_reg[ptr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            v_reg    <= {{(SUM_W-SMP_W){sample_value[SMP_W-1]}}, sample_value};
            w_reg    <= {{(SUM_W-SMP_W){sample_weight[SMP_W-1]}}, sample_weight};
            off_reg  <= off_tab[bucket_offset];
        end
        if (cmd.rd_exec)
        begin
            ex_val_reg <= bkt_vld_reg[ex_addr] ? val_mem[ex_addr] : '0;
            ex_wt_reg  <= bkt_vld_reg[ex_addr] ? wt_mem[ex_addr] : '0;
        end
        if (cmd.exec && wr_en)
        begin
            val_mem[ex_addr] <= wr_val;
            wt_mem[ex_addr]  <= wr_wt;
        end
        if (cmd.avg_wr)
            avg_mem[ptr_reg] <= div_q;
        if (cmd.out_load)
        begin
            cur_avg_reg <= avg_vld_reg[ptr_reg] ? avg_mem[ptr_reg] : '0;
            rd_avg_reg  <= avg_vld_reg[a_addr] ? avg_mem[a_addr] : '0;
            rd_val_reg  <= bkt_vld_reg[a_addr] ? val_mem[a_addr] : '0;
            rd_wt_reg   <= bkt_vld_reg[a_addr] ? wt_mem[a_addr] : '0;
            tot_val_reg <= vsum_reg;
            tot_wt_reg  <= wsum_reg;
        end
    end

    swwa_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (vsum_reg),
        .den   (wsum_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign sts.advance  = advance;
    assign sts.div_done = div_done;

    assign current_average  = cur_avg_reg;
    assign total_value_out  = tot_val_reg;
    assign total_weight_out = tot_wt_reg;
    assign read_value       = rd_val_reg;
    assign read_weight      = rd_wt_reg;
    assign read_average     = rd_avg_reg;

endmodule

/* verif/tb_sliding_window_weighted_average.sv */
module tb_sliding_window_weighted_average;
    import swwa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam int NBUCKETS    = WINDOW_BUCKETS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [AVG_W-1:0] cur_avg;
        logic [SUM_W-1:0] tot_val;
        logic [SUM_W-1:0] tot_wt;
        logic [SUM_W-1:0] rd_val;
        logic [SUM_W-1:0] rd_wt;
        logic [AVG_W-1:0] rd_avg;
    } window_result_t;

    class window_average_tracker;
        logic [SUM_W-1:0]  bucket_val [NBUCKETS];
        logic [SUM_W-1:0]  bucket_wt [NBUCKETS];
        logic [AVG_W-1:0]  bucket_avg [NBUCKETS];
        logic [SUM_W-1:0]  sum_val;
        logic [SUM_W-1:0]  sum_wt;
        int                ptr;
        logic [TICK_W-1:0] tick_cnt;
        logic [TICK_W-1:0] period;
        window_result_t    pending_results [$];
        int                errors;

        function new();
            for (int i = 0; i < NBUCKETS; i++)
            begin
                bucket_val[i] = '0;
                bucket_wt[i]  = '0;
                bucket_avg[i] = '0;
            end
            sum_val  = '0;
            sum_wt   = '0;
            ptr      = 0;
            tick_cnt = '0;
            period   = 16'd1;
            errors   = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void report(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        // Update the window for one accepted item and queue what it should return.
        function void apply_item(logic [MODE_W-1:0] mode, logic [SMP_W-1:0] v32,
                                 logic [SMP_W-1:0] w32, logic [OFFSET_W-1:0] off);
            logic [SUM_W-1:0] v;
            logic [SUM_W-1:0] w;
            int               a;
            int               eff_period;
            longint           num;
            longint           den;
            longint           quo;
            window_result_t   r;
            v = {{(SUM_W-SMP_W){v32[SMP_W-1]}}, v32};
            w = {{(SUM_W-SMP_W){w32[SMP_W-1]}}, w32};
            a = (ptr + int'(off)) % NBUCKETS;
            case (mode)
                MODE_ADD:
                begin
                    bucket_val[ptr] = bucket_val[ptr] + v;
                    bucket_wt[ptr]  = bucket_wt[ptr] + w;
                    sum_val = sum_val + v;
                    sum_wt  = sum_wt + w;
                end
                MODE_SUB:
                begin
                    bucket_val[ptr] = bucket_val[ptr] - v;
                    bucket_wt[ptr]  = bucket_wt[ptr] - w;
                    sum_val = sum_val - v;
                    sum_wt  = sum_wt - w;
                end
                MODE_TICK:
                begin
                    eff_period = (period == 0) ? 1 : int'(period);
                    if (int'(tick_cnt) + 1 < eff_period)
                        tick_cnt = tick_cnt + 1'b1;
                    else
                    begin
                        // oldest bucket leaves the window, then gets the new average
                        tick_cnt = '0;
                        ptr = (ptr + 1) % NBUCKETS;
                        sum_val = sum_val - bucket_val[ptr];
                        sum_wt  = sum_wt - bucket_wt[ptr];
                        bucket_val[ptr] = '0;
                        bucket_wt[ptr]  = '0;
                        num = $signed(sum_val);
                        den = $signed(sum_wt);
                        if (den == 0)
                            quo = 0;
                        else
                            quo = num / den;
                        if (quo > 64'sd2147483647)
                            quo = 64'sd2147483647;
                        if (quo < -64'sd2147483648)
                            quo = -64'sd2147483648;
                        bucket_avg[ptr] = quo[AVG_W-1:0];
                    end
                end
                MODE_WR_VAL:
                begin
                    sum_val = sum_val - bucket_val[a] + v;
                    bucket_val[a] = v;
                end
                MODE_WR_WT:
                begin
                    sum_wt = sum_wt - bucket_wt[a] + w;
                    bucket_wt[a] = w;
                end
                default:
                begin
                end
            endcase
            a = (ptr + int'(off)) % NBUCKETS;
            r.cur_avg = bucket_avg[ptr];
            r.tot_val = sum_val;
            r.tot_wt  = sum_wt;
            r.rd_val  = bucket_val[a];
            r.rd_wt   = bucket_wt[a];
            r.rd_avg  = bucket_avg[a];
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [SUM_W-1:0] got,
                                    logic [SUM_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endfunction

        function void check_result(window_result_t got);
            window_result_t want;
            if (pending_results.size() == 0)
            begin
                report("result with no item outstanding");
                return;
            end
            want = pending_results.pop_front();
            compare_field("current_average", SUM_W'(got.cur_avg), SUM_W'(want.cur_avg));
            compare_field("total_value_out", got.tot_val, want.tot_val);
            compare_field("total_weight_out", got.tot_wt, want.tot_wt);
            compare_field("read_value", got.rd_val, want.rd_val);
            compare_field("read_weight", got.rd_wt, want.rd_wt);
            compare_field("read_average", SUM_W'(got.rd_avg), SUM_W'(want.rd_avg));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_wdata;
    int                cycle_count = 0;
    bit                steady = 1'b0;
    window_average_tracker tracker;

    swwa_in_if  req_if ();
    swwa_out_if rsp_if ();

    sliding_window_weighted_average #(
        .WINDOW_BUCKETS (NBUCKETS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Small numbers so averages stay meaningful, mixed with the extremes and random values.
    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom;
            default: return 32'($urandom_range(0, 64)) - 32'd16;
        endcase
    endfunction

    task automatic send_item(logic [MODE_W-1:0] mode, logic [SMP_W-1:0] v,
                             logic [SMP_W-1:0] w, logic [OFFSET_W-1:0] off);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.mode          <= mode;
        req_if.sample_value  <= v;
        req_if.sample_weight <= w;
        req_if.bucket_offset <= off;
        do
            @(posedge clk);
        while (!req_if.ready);
        tracker.apply_item(mode, v, w, off);
    endtask

    task automatic send_random(int count);
        int               pick;
        logic [MODE_W-1:0] mode;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
                steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                mode = MODE_ADD;
            else if (pick < 45)
                mode = MODE_SUB;
            else if (pick < 65)
                mode = MODE_TICK;
            else if (pick < 75)
                mode = MODE_READ;
            else if (pick < 85)
                mode = MODE_WR_VAL;
            else if (pick < 95)
                mode = MODE_WR_WT;
            else
                mode = pick[0] ? MODE_SPARE_7 : MODE_SPARE_6;
            send_item(mode, pick_sample(), pick_sample(), OFFSET_W'($urandom_range(0, 15)));
        end
        steady = 1'b0;
    endtask

    // Lower valid and hold off until every outstanding result is back.
    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_period(logic [TICK_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.period = value;
    endtask

    task automatic send_tick();
        send_item(MODE_TICK, $urandom, $urandom, OFFSET_W'($urandom_range(0, 15)));
    endtask

    // result side
    initial
    begin
        int             gap;
        window_result_t got;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            got.cur_avg = rsp_if.current_average;
            got.tot_val = rsp_if.total_value_out;
            got.tot_wt  = rsp_if.total_weight_out;
            got.rd_val  = rsp_if.read_value;
            got.rd_wt   = rsp_if.read_weight;
            got.rd_avg  = rsp_if.read_average;
            tracker.check_result(got);
        end
    end

    initial
    begin
        tracker = new;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_ADD;
        req_if.sample_value  = '0;
        req_if.sample_weight = '0;
        req_if.bucket_offset = '0;
        rsp_if.ready         = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        write_period(16'd1);
        // zero weight sum, then positive and negative saturation of the average
        send_tick();
        send_item(MODE_ADD, 32'h7FFF_FFFF, 32'd1, 4'd0);
        send_item(MODE_ADD, 32'h7FFF_FFFF, 32'd0, 4'd15);
        send_tick();
        repeat (4) send_item(MODE_ADD, 32'h8000_0000, 32'd0, 4'd8);
        send_tick();
        send_item(MODE_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd3);
        send_item(MODE_SUB, 32'h8000_0000, 32'h8000_0000, 4'd15);
        send_item(MODE_READ, 32'h0, 32'h0, 4'd0);
        send_item(MODE_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(MODE_WR_VAL, 32'h7FFF_FFFF, 32'h0, 4'd15);
        send_item(MODE_WR_WT, 32'h0, 32'h8000_0000, 4'd15);
        send_item(MODE_WR_VAL, 32'h8000_0000, 32'h1, 4'd0);
        send_item(MODE_WR_WT, 32'h5, 32'h7FFF_FFFF, 4'd1);
        send_item(MODE_SPARE_6, 32'h1234_5678, 32'h9ABC_DEF0, 4'd7);
        send_item(MODE_SPARE_7, 32'hFFFF_FFFF, 32'h8000_0000, 4'd9);
        send_item(MODE_ADD, 32'hFFFF_FFF9, 32'd2, 4'd2);
        send_tick();
        send_item(MODE_READ, 32'h0, 32'h0, 4'd1);
        drain();

        // a zero period behaves as one
        write_period(16'd0);
        send_random(120);
        drain();

        write_period(16'd3);
        send_random(60);
        drain();
        send_random(60);
        drain();

        // lower the period while the tick count is above the new value
        write_period(16'd5);
        repeat (3) send_tick();
        drain();
        write_period(16'd2);
        send_tick();
        send_random(40);
        drain();

        write_period(16'hFFFF);
        send_random(100);
        drain();
        write_period(16'd1);
        send_tick();
        drain();

        write_period(TICK_W'($urandom_range(1, 4)));
        send_random(200);
        drain();

        repeat (60) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
